// File: design/ihrw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intel HEX record writer package
// Shared widths, codes, character constants and the emitter command type.
// ----------------------------------------------------------------------------
package ihrw_pkg;

	localparam int ACTION_W  = 2;
	localparam int BYTE_W    = 8;
	localparam int ADDR_W    = 32;
	localparam int CHAR_W    = 7;
	localparam int FILL_W    = 5;
	localparam int UPPER_W   = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 5;

	localparam int MAX_RECORD_DEFAULT = 16;
	localparam logic [FILL_W-1:0] RECORD_SIZE_RESET = 5'd10;

	// Input actions.
	localparam logic [ACTION_W-1:0] ACT_DATA  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_SETPOS = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_FLUSH = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_EOF   = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE   = 1'b1;

	// Record type bytes.
	localparam logic [BYTE_W-1:0] REC_DATA    = 8'h00;
	localparam logic [BYTE_W-1:0] REC_EOF     = 8'h01;
	localparam logic [BYTE_W-1:0] REC_EXT_SEG = 8'h02;
	localparam logic [BYTE_W-1:0] REC_EXT_LIN = 8'h04;

	localparam logic [CHAR_W-1:0] CH_COLON   = 7'h3A;
	localparam logic [CHAR_W-1:0] CH_NEWLINE = 7'h0A;

	// Request from the control logic to the character emitter.
	typedef struct packed {
		logic                go;
		logic                eof;
		logic                ext;
		logic [BYTE_W-1:0]   ext_type;
		logic [UPPER_W-1:0]  ext_value;
		logic [UPPER_W-1:0]  start_low;
		logic [FILL_W-1:0]   count;
	} ihrw_cmd_t;

	// Uppercase ASCII hex digit of a nibble.
	function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
		logic [CHAR_W-1:0] c;
		if (nib < 4'd10) begin
			c = 7'h30 + {3'b000, nib};
		end else begin
			c = 7'h37 + {3'b000, nib};
		end
		return c;
	endfunction

endpackage

// File: design/ihrw_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intel HEX record writer channels
// Valid/ready channel bundles for the input requests and the output characters.
// ----------------------------------------------------------------------------
interface ihrw_item_if import ihrw_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [BYTE_W-1:0]   data_byte;
	logic [ADDR_W-1:0]   address;

	modport source (output valid, action, data_byte, address, input ready);
	modport sink (input valid, action, data_byte, address, output ready);
endinterface

interface ihrw_char_if import ihrw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] ascii_char;
	logic              last_char;

	modport source (output valid, ascii_char, last_char, input ready);
	modport sink (input valid, ascii_char, last_char, output ready);
endinterface

// File: design/ihrw_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record byte buffer
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module ihrw_buffer import ihrw_pkg::*; #(
	parameter int DEPTH = MAX_RECORD_DEFAULT,
	parameter int IDX_W = 4
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_addr,
	input  logic [BYTE_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [IDX_W-1:0]  rd_addr,
	output logic [BYTE_W-1:0] rd_data
);

	logic [BYTE_W-1:0] mem_q [DEPTH];
	logic [BYTE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: design/ihrw_emitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record character emitter
// Walks the bytes of one or two records and sends them as ASCII hex text.
// ----------------------------------------------------------------------------
module ihrw_emitter import ihrw_pkg::*; #(
	parameter int IDX_W = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ihrw_cmd_t          cmd,
	output logic               idle,
	output logic               rd_en,
	output logic [IDX_W-1:0]   rd_addr,
	input  logic [BYTE_W-1:0]  rd_data,
	ihrw_char_if.source        chars
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_COLON = 3'd1;
	localparam logic [2:0] ST_HI    = 3'd2;
	localparam logic [2:0] ST_LO    = 3'd3;
	localparam logic [2:0] ST_FETCH = 3'd4;
	localparam logic [2:0] ST_NL    = 3'd5;

	localparam logic [1:0] K_EXT  = 2'd0;
	localparam logic [1:0] K_DATA = 2'd1;
	localparam logic [1:0] K_EOF  = 2'd2;

	localparam logic [FILL_W-1:0] HDR_BYTES = 5'd4;
	localparam logic [FILL_W-1:0] EXT_LEN   = 5'd2;

	logic [2:0]          state_q;
	logic [1:0]          kind_q;
	logic [FILL_W-1:0]   bidx_q;
	logic [BYTE_W-1:0]   sum_q;
	logic [FILL_W-1:0]   count_q;
	logic [BYTE_W-1:0]   ext_type_q;
	logic [UPPER_W-1:0]  ext_value_q;
	logic [UPPER_W-1:0]  start_low_q;

	logic                ovalid_q;
	logic [CHAR_W-1:0]   ochar_q;
	logic                olast_q;

	logic [FILL_W-1:0]   len;
	logic [FILL_W-1:0]   cks_idx;
	logic [FILL_W-1:0]   nidx;
	logic [BYTE_W-1:0]   cur_byte;
	logic                emit;
	logic [CHAR_W-1:0]   emit_char;
	logic                emit_last;
	logic                slot_free;
	logic                adv;

	always_comb begin
		case (kind_q)
			K_EXT:   len = EXT_LEN;
			K_DATA:  len = count_q;
			default: len = '0;
		endcase
		cks_idx = HDR_BYTES + len;
		nidx    = bidx_q + 5'd1;
	end

	always_comb begin
		cur_byte = rd_data;
		if (bidx_q == cks_idx) begin
			cur_byte = 8'h00 - sum_q;
		end else begin
			case (bidx_q)
				5'd0: cur_byte = {3'b000, len};
				5'd1: cur_byte = (kind_q == K_DATA) ? start_low_q[15:8] : 8'h00;
				5'd2: cur_byte = (kind_q == K_DATA) ? start_low_q[7:0] : 8'h00;
				5'd3: begin
					case (kind_q)
						K_EXT:   cur_byte = ext_type_q;
						K_DATA:  cur_byte = REC_DATA;
						default: cur_byte = REC_EOF;
					endcase
				end
				default: begin
					if (kind_q == K_EXT) begin
						cur_byte = (bidx_q == HDR_BYTES) ? ext_value_q[15:8] : ext_value_q[7:0];
					end else begin
						cur_byte = rd_data;
					end
				end
			endcase
		end
	end

	always_comb begin
		emit      = 1'b0;
		emit_char = CH_COLON;
		emit_last = 1'b0;
		case (state_q)
			ST_COLON: begin
				emit      = 1'b1;
				emit_char = CH_COLON;
			end
			ST_HI: begin
				emit      = 1'b1;
				emit_char = hex_char(cur_byte[7:4]);
			end
			ST_LO: begin
				emit      = 1'b1;
				emit_char = hex_char(cur_byte[3:0]);
				emit_last = (kind_q == K_EOF) && (bidx_q == cks_idx);
			end
			ST_NL: begin
				emit      = 1'b1;
				emit_char = CH_NEWLINE;
				emit_last = (kind_q == K_DATA);
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	assign slot_free = !ovalid_q || chars.ready;
	assign adv       = emit ? slot_free : 1'b1;
	assign idle      = (state_q == ST_IDLE);
	assign rd_en     = (state_q == ST_FETCH);
	assign rd_addr   = IDX_W'(bidx_q - HDR_BYTES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q  <= K_DATA;
			bidx_q  <= '0;
			sum_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.go) begin
						state_q <= ST_COLON;
						if (cmd.eof) begin
							kind_q <= K_EOF;
						end else if (cmd.ext) begin
							kind_q <= K_EXT;
						end else begin
							kind_q <= K_DATA;
						end
					end
				end
				ST_COLON: begin
					if (adv) begin
						bidx_q  <= '0;
						sum_q   <= '0;
						state_q <= ST_HI;
					end
				end
				ST_HI: begin
					if (adv) begin
						state_q <= ST_LO;
					end
				end
				ST_LO: begin
					if (adv) begin
						sum_q  <= sum_q + cur_byte;
						bidx_q <= nidx;
						if (bidx_q == cks_idx) begin
							state_q <= (kind_q == K_EOF) ? ST_IDLE : ST_NL;
						end else if (kind_q == K_DATA && nidx >= HDR_BYTES
								&& nidx != cks_idx) begin
							state_q <= ST_FETCH;
						end else begin
							state_q <= ST_HI;
						end
					end
				end
				ST_FETCH: begin
					state_q <= ST_HI;
				end
				ST_NL: begin
					if (adv) begin
						if (kind_q == K_EXT) begin
							kind_q  <= K_DATA;
							state_q <= ST_COLON;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Record fields are captured with the request and stay put until it is done.
	always_ff @(posedge clk) begin
		if (idle && cmd.go) begin
			count_q     <= cmd.count;
			ext_type_q  <= cmd.ext_type;
			ext_value_q <= cmd.ext_value;
			start_low_q <= cmd.start_low;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (emit && slot_free) begin
			ovalid_q <= 1'b1;
		end else if (chars.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && slot_free) begin
			ochar_q <= emit_char;
			olast_q <= emit_last;
		end
	end

	assign chars.valid      = ovalid_q;
	assign chars.ascii_char = ochar_q;
	assign chars.last_char  = olast_q;

endmodule

// File: design/intel_hex_record_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intel HEX record writer
// Buffers data bytes and streams Intel HEX records as ASCII characters.
// ----------------------------------------------------------------------------
// A data byte, set-position, flush or end-of-file request is accepted only
// while the character emitter is idle; the block works on one request at a
// time. Requests that produce no text (a buffered byte, a position change, a
// flush with nothing buffered) are done once they are accepted. Text leaves
// at one character per cycle while the receiver is ready, apart from memory
// reads, through a registered output stage, so a pending last character
// never holds off the next request. A data record takes one step per
// character, plus one memory read ahead of each buffered byte, since the
// bytes sit in a buffer memory with registered read data. An extended
// address record is sent first whenever the upper 16 address bits of the
// record start differ from the last ones sent. The end-of-file record
// ":00000001FF" has no newline. Output stalls hold the emitter in place.
// Configuration writes (index 0 format, index 1 record size) are meant to
// happen while no text is pending.
// ----------------------------------------------------------------------------
module intel_hex_record_writer import ihrw_pkg::*; #(
	parameter int MAX_RECORD = MAX_RECORD_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	ihrw_item_if.sink             items,
	ihrw_char_if.source           chars
);

	localparam int IDX_W = (MAX_RECORD > 1) ? $clog2(MAX_RECORD) : 1;
	localparam logic [FILL_W-1:0] MAX_FILL = FILL_W'(MAX_RECORD);

	// Configuration registers.
	logic               fmt_q;
	logic [FILL_W-1:0]  rsz_q;

	// Writer state kept in flip-flops; the record bytes live in the buffer.
	logic [FILL_W-1:0]  fill_q;
	logic [ADDR_W-1:0]  pos_q;
	logic [UPPER_W-1:0] lua_q;

	logic               idle;
	logic               accept;
	logic               is_data;
	logic [FILL_W-1:0]  eff_size;
	logic [FILL_W-1:0]  fill_n;
	logic [ADDR_W-1:0]  pos_n;
	logic [FILL_W-1:0]  rec_count;
	logic [ADDR_W-1:0]  start_addr;
	logic [UPPER_W-1:0] upper;
	logic               launch;
	ihrw_cmd_t          cmd;
	logic               rd_en;
	logic [IDX_W-1:0]   rd_addr;
	logic [BYTE_W-1:0]  rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= 1'b0;
			rsz_q <= RECORD_SIZE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FORMAT: fmt_q <= cfg_data[0];
				REG_SIZE:   rsz_q <= cfg_data;
				default:    fmt_q <= fmt_q;
			endcase
		end
	end

	// A zero size behaves as one, anything above the buffer depth as the depth.
	always_comb begin
		if (rsz_q == '0) begin
			eff_size = 5'd1;
		end else if (rsz_q > MAX_FILL) begin
			eff_size = MAX_FILL;
		end else begin
			eff_size = rsz_q;
		end
	end

	assign items.ready = idle;
	assign accept      = items.valid && idle;
	assign is_data     = (items.action == ACT_DATA);
	assign fill_n      = fill_q + 5'd1;
	assign pos_n       = pos_q + 32'd1;

	// The start address is taken after the byte is counted, so a completing
	// byte and a flush share one subtract.
	assign rec_count  = is_data ? fill_n : fill_q;
	assign start_addr = (is_data ? pos_n : pos_q) - {{(ADDR_W-FILL_W){1'b0}}, rec_count};
	assign upper      = start_addr[31:16];

	always_comb begin
		case (items.action)
			ACT_DATA:  launch = accept && (fill_n >= eff_size);
			ACT_FLUSH: launch = accept && (fill_q != '0);
			default:   launch = 1'b0;
		endcase
	end

	always_comb begin
		cmd.go        = launch || (accept && items.action == ACT_EOF);
		cmd.eof       = (items.action == ACT_EOF);
		cmd.ext       = (upper != lua_q);
		cmd.ext_type  = fmt_q ? REC_EXT_SEG : REC_EXT_LIN;
		cmd.ext_value = fmt_q ? {upper[3:0], 12'h000} : upper;
		cmd.start_low = start_addr[15:0];
		cmd.count     = rec_count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			pos_q  <= '0;
			lua_q  <= '0;
		end else if (accept) begin
			case (items.action)
				ACT_DATA: begin
					pos_q  <= pos_n;
					fill_q <= launch ? '0 : fill_n;
				end
				ACT_SETPOS: begin
					pos_q <= items.address;
				end
				ACT_FLUSH: begin
					fill_q <= '0;
				end
				default: begin
					fill_q <= fill_q;
				end
			endcase
			// The emitter holds its own copy of the count, so the fill clears
			// as soon as the record is handed over.
			if (launch) begin
				lua_q <= upper;
			end
		end
	end

	ihrw_buffer #(
		.DEPTH (MAX_RECORD),
		.IDX_W (IDX_W)
	) u_buffer (
		.clk     (clk),
		.wr_en   (accept && is_data),
		.wr_addr (fill_q[IDX_W-1:0]),
		.wr_data (items.data_byte),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Reads come only after the last write of a record has landed and no
	// write is taken while the emitter runs, so no forwarding is needed.
	ihrw_emitter #(
		.IDX_W (IDX_W)
	) u_emitter (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.idle    (idle),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.chars   (chars)
	);

`ifndef SYNTH
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= MAX_FILL)
		else $error("buffer fill beyond depth");

	a_eof_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && items.action == ACT_EOF |=> !items.ready)
		else $error("end-of-file request did not start the emitter");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(items.ready) |-> chars.valid && chars.last_char)
		else $error("emitter finished without a last character");

	a_setpos: assert property (@(posedge clk) disable iff (!arst_n)
		accept && items.action == ACT_SETPOS |=> pos_q == $past(items.address))
		else $error("position not taken from set-position request");
`endif

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intel HEX record writer testbench
// Drives byte, position, flush and end-of-file requests with random gaps on
// both channels and checks every emitted character against a local model.
// ----------------------------------------------------------------------------
module tb_top;
	import ihrw_pkg::*;

	localparam int LIMIT  = 400000;  // cycle budget for the whole run
	localparam int SETTLE = 20;      // quiet cycles before a register write
	localparam int CHUNK  = 75;      // random requests per configuration phase

	// One expected character of record text.
	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              last;
	} text_char_t;

	// ------------------------------------------------------------------------
	// Record text model and checker. It keeps its own copy of the buffer,
	// the byte position, the last upper address sent and both registers, and
	// turns each accepted request into the characters the block must send.
	// ------------------------------------------------------------------------
	class record_text_checker;
		logic [BYTE_W-1:0]  rec_bytes[MAX_RECORD_DEFAULT];
		int unsigned        fill;
		logic [ADDR_W-1:0]  pos;
		logic [UPPER_W-1:0] last_upper;
		logic               seg_mode;
		logic [FILL_W-1:0]  rec_size;
		text_char_t         awaited_text[$];
		int                 errors;

		function new();
			fill = 0;
			pos = '0;
			last_upper = '0;
			seg_mode = 1'b0;
			rec_size = RECORD_SIZE_RESET;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_FORMAT: seg_mode = val[0];
				REG_SIZE:   rec_size = val;
				default:    ;
			endcase
		endfunction

		function void add_char(logic [CHAR_W-1:0] c);
			text_char_t t;
			t.code = c;
			t.last = 1'b0;
			awaited_text.push_back(t);
		endfunction

		// Two uppercase hex digits, high nibble first.
		function void add_hex(logic [BYTE_W-1:0] v);
			logic [3:0] nib;
			for (int k = 1; k >= 0; k--) begin
				nib = (k == 1) ? v[7:4] : v[3:0];
				if (nib < 4'd10)
					add_char(7'h30 + CHAR_W'(nib));
				else
					add_char(7'h41 + CHAR_W'(nib - 4'd10));
			end
		endfunction

		function void add_ext_record(logic [BYTE_W-1:0] kind, logic [UPPER_W-1:0] value);
			logic [BYTE_W-1:0] sum;
			sum = 8'd2 + kind + value[15:8] + value[7:0];
			add_char(CH_COLON);
			add_hex(8'd2);
			add_hex(8'd0);
			add_hex(8'd0);
			add_hex(kind);
			add_hex(value[15:8]);
			add_hex(value[7:0]);
			add_hex(-sum);
			add_char(CH_NEWLINE);
		endfunction

		// A data record for everything buffered, preceded by an extended
		// address record when the upper half of the start address moved.
		function void add_data_record();
			logic [ADDR_W-1:0]  start;
			logic [BYTE_W-1:0]  sum;
			start = pos - ADDR_W'(fill);
			if (start[31:16] != last_upper) begin
				last_upper = start[31:16];
				if (seg_mode)
					add_ext_record(REC_EXT_SEG, {start[19:16], 12'h000});
				else
					add_ext_record(REC_EXT_LIN, start[31:16]);
			end
			sum = BYTE_W'(fill) + start[15:8] + start[7:0] + REC_DATA;
			add_char(CH_COLON);
			add_hex(BYTE_W'(fill));
			add_hex(start[15:8]);
			add_hex(start[7:0]);
			add_hex(REC_DATA);
			for (int i = 0; i < fill && i < MAX_RECORD_DEFAULT; i++) begin
				sum += rec_bytes[i];
				add_hex(rec_bytes[i]);
			end
			add_hex(-sum);
			add_char(CH_NEWLINE);
			fill = 0;
		endfunction

		function void note_request(logic [ACTION_W-1:0] act, logic [BYTE_W-1:0] b,
				logic [ADDR_W-1:0] a);
			int unsigned before_cnt;
			int unsigned limit;
			text_char_t  t;
			before_cnt = awaited_text.size();
			// Out-of-range record sizes clamp to the nearest legal size.
			limit = (rec_size == 0) ? 1 :
				(rec_size > MAX_RECORD_DEFAULT) ? MAX_RECORD_DEFAULT : rec_size;
			case (act)
				ACT_DATA: begin
					if (fill < MAX_RECORD_DEFAULT)
						rec_bytes[fill] = b;
					fill++;
					pos++;
					// A size lowered below the fill completes the record here.
					if (fill >= limit)
						add_data_record();
				end
				ACT_SETPOS: begin
					pos = a;
				end
				ACT_FLUSH: begin
					if (fill != 0)
						add_data_record();
				end
				default: begin
					// End of file leaves buffered bytes where they are.
					add_char(CH_COLON);
					add_hex(8'h00);
					add_hex(8'h00);
					add_hex(8'h00);
					add_hex(REC_EOF);
					add_hex(8'hFF);
				end
			endcase
			if (awaited_text.size() > before_cnt) begin
				t = awaited_text.pop_back();
				t.last = 1'b1;
				awaited_text.push_back(t);
			end
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 30)
				$display("%0t ns: mismatch: %s", $time, msg);
		endtask

		task check_char(logic [CHAR_W-1:0] c, logic last);
			text_char_t t;
			if (awaited_text.size() == 0) begin
				report($sformatf("unexpected character 0x%0h last=%0b", c, last));
			end else begin
				t = awaited_text.pop_front();
				if (c !== t.code)
					report($sformatf("character 0x%0h, wanted 0x%0h", c, t.code));
				if (last !== t.last)
					report($sformatf("last flag %0b, wanted %0b on 0x%0h", last, t.last,
						t.code));
			end
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	ihrw_item_if item_ch ();
	ihrw_char_if char_ch ();

	intel_hex_record_writer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.items     (item_ch),
		.chars     (char_ch)
	);

	record_text_checker sb = new();

	// Percent chances of a gap on the request side and of a stall on the
	// character side, and the length of a forced receiver hold-off.
	int tx_idle_pct;
	int rx_idle_pct;
	int hold_left;
	int unsigned cycles;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// The whole run is bounded; a hang anywhere ends up here.
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// The character receiver. Ready changes only on the falling edge. A
	// hold-off keeps it low until its counter runs out, which lets the
	// output stage fill up and back-pressure the request side.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			char_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			char_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Every accepted character is checked against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && char_ch.valid && char_ch.ready)
			sb.check_char(char_ch.ascii_char, char_ch.last_char);
	end

	// Offers one request, with an optional gap in front of it, and returns
	// right after the edge that accepted it. Valid stays high on return so
	// that a following request can go out back to back.
	task automatic send_request(logic [ACTION_W-1:0] act, logic [BYTE_W-1:0] b,
			logic [ADDR_W-1:0] a);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.action <= act;
		item_ch.data_byte <= b;
		item_ch.address <= a;
		do
			@(posedge clk);
		while (!item_ch.ready);
		sb.note_request(act, b, a);
	endtask

	// Drops valid and waits until every expected character has come, then
	// lets the block settle for requests that make no text.
	task automatic wait_drain();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (sb.awaited_text.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Both registers for one phase. The format write carries random upper
	// bits, which the block must ignore.
	task automatic set_phase(logic fmt, logic [CFG_DATA_W-1:0] size);
		logic [CFG_DATA_W-2:0] junk;
		junk = (CFG_DATA_W-1)'($urandom);
		write_reg(REG_FORMAT, {junk, fmt});
		write_reg(REG_SIZE, size);
	endtask

	// Mostly data bytes, so records fill and go out often; flushes, position
	// changes and end-of-file requests are mixed in. New positions either
	// jump anywhere, land just below a 64 KiB boundary, land just below the
	// top of the address space, or stay within the current upper half.
	task automatic run_random(int n);
		int                roll;
		logic [ACTION_W-1:0] act;
		logic [BYTE_W-1:0] b;
		logic [ADDR_W-1:0] a;
		logic [ADDR_W-1:0] up;
		for (int i = 0; i < n; i++) begin
			roll = $urandom_range(99);
			b = BYTE_W'($urandom);
			a = $urandom;
			if (roll < 72) begin
				act = ACT_DATA;
			end else if (roll < 82) begin
				act = ACT_FLUSH;
			end else if (roll < 95) begin
				act = ACT_SETPOS;
				up = $urandom;
				case ($urandom_range(3))
					0: a = up;
					1: a = {up[15:0], 12'hFFF, 4'($urandom_range(15))};
					2: a = {28'hFFFFFFF, 4'($urandom_range(15))};
					default: a = {sb.pos[31:16], up[15:0]};
				endcase
			end else begin
				act = ACT_EOF;
			end
			send_request(act, b, a);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item_ch.valid = 1'b0;
		item_ch.action = ACT_DATA;
		item_ch.data_byte = '0;
		item_ch.address = '0;
		char_ch.ready = 1'b0;
		tx_idle_pct = 6;
		rx_idle_pct = 48;
		hold_left = 0;
		cycles = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// Directed part, starting from the reset settings: linear extended
		// records and ten bytes per record.
		send_request(ACT_EOF, 8'h00, 32'h0);
		send_request(ACT_FLUSH, 8'h00, 32'h0);  // nothing buffered, no text
		send_request(ACT_DATA, 8'h00, 32'hFFFF_FFFF);
		send_request(ACT_DATA, 8'hFF, 32'h0);
		send_request(ACT_DATA, 8'hA5, 32'h0);
		send_request(ACT_DATA, 8'h5A, 32'h0);
		send_request(ACT_FLUSH, 8'hFF, 32'h0);
		// A record that starts just below a 64 KiB boundary.
		send_request(ACT_SETPOS, 8'h00, 32'h0001_FFFE);
		send_request(ACT_DATA, 8'h01, 32'h0);
		send_request(ACT_DATA, 8'h02, 32'h0);
		send_request(ACT_DATA, 8'h03, 32'h0);
		send_request(ACT_FLUSH, 8'h00, 32'h0);
		// A position change with a byte still buffered, then a wrap of the
		// position past the top of the address space.
		send_request(ACT_DATA, 8'h11, 32'h0);
		send_request(ACT_SETPOS, 8'h00, 32'hFFFF_FFFF);
		send_request(ACT_DATA, 8'h22, 32'h0);
		send_request(ACT_FLUSH, 8'h00, 32'h0);
		// End of file while a byte is buffered; the flush sends it after.
		send_request(ACT_DATA, 8'h33, 32'h0);
		send_request(ACT_EOF, 8'h00, 32'h0);
		send_request(ACT_FLUSH, 8'h00, 32'h0);
		wait_drain();

		// Segment records and a record size of zero, which acts as one.
		set_phase(1'b1, 5'd0);
		send_request(ACT_SETPOS, 8'h00, 32'h1234_5678);
		send_request(ACT_DATA, 8'h80, 32'h0);
		wait_drain();

		// Buffer a few bytes, then lower the size below the fill: the next
		// byte must complete a record holding all of them.
		set_phase(1'b1, 5'd16);
		send_request(ACT_DATA, 8'hC3, 32'h0);
		send_request(ACT_DATA, 8'h3C, 32'h0);
		send_request(ACT_DATA, 8'h7E, 32'h0);
		wait_drain();
		set_phase(1'b0, 5'd2);
		send_request(ACT_DATA, 8'h81, 32'h0);
		wait_drain();

		// Random part. Sender-light gaps with a busy receiver first.
		set_phase(1'b0, 5'd16);
		run_random(CHUNK);
		wait_drain();
		set_phase(1'b1, 5'd1);
		run_random(CHUNK);
		wait_drain();

		// Then a gappy sender and a mostly ready receiver.
		tx_idle_pct = 48;
		rx_idle_pct = 6;
		set_phase(1'b1, 5'd31);
		run_random(CHUNK);
		wait_drain();
		set_phase(1'b0, 5'd0);
		run_random(CHUNK);
		wait_drain();

		// No gaps at all, opened by a long receiver hold-off while requests
		// keep coming, so the block has to stall its request side.
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_phase(1'b1, CFG_DATA_W'($urandom_range(31)));
		hold_left = 300;
		run_random(CHUNK);
		wait_drain();
		set_phase(1'b0, CFG_DATA_W'($urandom_range(1, 16)));
		run_random(CHUNK);
		wait_drain();

		if (sb.awaited_text.size() != 0)
			sb.report($sformatf("%0d characters never arrived", sb.awaited_text.size()));
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: intel_hex_record_writer.f
design/ihrw_pkg.sv
design/ihrw_ifs.sv
design/ihrw_buffer.sv
design/ihrw_emitter.sv
design/intel_hex_record_writer.sv
test/tb_top.sv
